>>> sv/tcel_pkg.sv
package tcel_pkg;

  localparam int TET_NUM = 6;
  localparam int CODE_W  = 4;
  localparam int LOCAL_W = 3;
  localparam int EDGE_W  = 5;
  localparam int CNT_W   = 3;
  localparam int TET_W   = 3;

  typedef logic [TET_NUM-1:0][CODE_W-1:0] tet_codes_t;
  typedef logic [5:0][LOCAL_W-1:0]        local_row_t;
  typedef logic [5:0][EDGE_W-1:0]         edge_row_t;

  typedef struct packed {
    tet_codes_t         code;
    logic [TET_NUM-1:0] busy;
  } tcel_entry_t;

  // cube corner for vertex i of tetrahedron t
  function automatic logic [2:0] tet_corner(input logic [TET_W-1:0] t,
                                            input logic [1:0] i);
    logic [3:0][2:0] row;
    case (t)
      3'd0:    row = {3'd7, 3'd3, 3'd1, 3'd0};
      3'd1:    row = {3'd7, 3'd5, 3'd1, 3'd0};
      3'd2:    row = {3'd7, 3'd3, 3'd2, 3'd0};
      3'd3:    row = {3'd7, 3'd6, 3'd2, 3'd0};
      3'd4:    row = {3'd7, 3'd5, 3'd4, 3'd0};
      3'd5:    row = {3'd7, 3'd6, 3'd4, 3'd0};
      default: row = '0;
    endcase
    return row[i];
  endfunction

  // vertex count of a tetrahedron case
  function automatic logic [CNT_W-1:0] tet_count(input logic [CODE_W-1:0] code);
    logic [CNT_W-1:0] n;
    case (code)
      4'd0, 4'd15:                             n = 3'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12:    n = 3'd6;
      default:                                 n = 3'd3;
    endcase
    return n;
  endfunction

  // local edges of a tetrahedron case, element 0 emitted first
  function automatic local_row_t tet_local(input logic [CODE_W-1:0] code);
    local_row_t row;
    case (code)
      4'd1:    row = {3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};
      4'd2:    row = {3'd0, 3'd0, 3'd0, 3'd3, 3'd4, 3'd0};
      4'd3:    row = {3'd1, 3'd4, 3'd2, 3'd1, 3'd3, 3'd4};
      4'd4:    row = {3'd0, 3'd0, 3'd0, 3'd1, 3'd5, 3'd3};
      4'd5:    row = {3'd2, 3'd5, 3'd3, 3'd2, 3'd3, 3'd0};
      4'd6:    row = {3'd1, 3'd5, 3'd4, 3'd1, 3'd4, 3'd0};
      4'd7:    row = {3'd0, 3'd0, 3'd0, 3'd5, 3'd4, 3'd2};
      4'd8:    row = {3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd2};
      4'd9:    row = {3'd4, 3'd5, 3'd1, 3'd1, 3'd0, 3'd4};
      4'd10:   row = {3'd3, 3'd5, 3'd2, 3'd3, 3'd2, 3'd0};
      4'd11:   row = {3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd5};
      4'd12:   row = {3'd4, 3'd1, 3'd2, 3'd3, 3'd1, 3'd4};
      4'd13:   row = {3'd0, 3'd0, 3'd0, 3'd4, 3'd3, 3'd0};
      4'd14:   row = {3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0};
      default: row = '0;
    endcase
    return row;
  endfunction

  // cube edges for local edges ab, ac, ad, bc, bd, cd
  function automatic edge_row_t tet_edge(input logic [TET_W-1:0] t);
    edge_row_t row;
    case (t)
      3'd0:    row = {5'd16, 5'd9,  5'd7,  5'd6, 5'd2, 5'd0};
      3'd1:    row = {5'd17, 5'd9,  5'd8,  5'd6, 5'd4, 5'd0};
      3'd2:    row = {5'd16, 5'd12, 5'd10, 5'd6, 5'd2, 5'd1};
      3'd3:    row = {5'd18, 5'd12, 5'd11, 5'd6, 5'd5, 5'd1};
      3'd4:    row = {5'd17, 5'd15, 5'd13, 5'd6, 5'd4, 5'd3};
      3'd5:    row = {5'd18, 5'd15, 5'd14, 5'd6, 5'd5, 5'd3};
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

>>> sv/tetra_cube_edge_list.sv
// channel | ports                                       | dir
// in      | in_valid, in_ready, in_corner_mask[7:0]     | in
// out     | out_valid, out_ready, out_edge_index[4:0],  | out
//         | out_end_of_cube, out_no_surface             |
// a cube is classified in the cycle it is accepted and queued; the back end
// then emits one edge index per cycle while not stalled, 3 to 36 per cube, or 1
// with no surface, so a cube holds the result port until its results are taken
// results leave through one output register, loaded only from a queued cube
// reset empties the queue and clears the output valid; a stalled out_ready holds
// the back end, and the front keeps taking items until the queue is full
module tetra_cube_edge_list #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_corner_mask,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_edge_index,
  output logic       out_end_of_cube,
  output logic       out_no_surface
);

  logic                  push, pop, q_full, head_valid;
  tcel_pkg::tcel_entry_t push_entry, head_entry;

  tcel_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .corner_mask (in_corner_mask),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  tcel_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  tcel_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_index  (out_edge_index),
    .end_of_cube (out_end_of_cube),
    .no_surface  (out_no_surface)
  );

endmodule

>>> sv/tcel_front.sv
module tcel_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           corner_mask,
  output logic                 push,
  output tcel_pkg::tcel_entry_t push_entry,
  input  logic                 q_full
);

  always_comb begin
    push_entry = '0;
    for (int t = 0; t < tcel_pkg::TET_NUM; t++) begin
      for (int i = 0; i < 4; i++) begin
        push_entry.code[t][3-i] =
          corner_mask[tcel_pkg::tet_corner(tcel_pkg::TET_W'(t), 2'(i))];
      end
      push_entry.busy[t] = (tcel_pkg::tet_count(push_entry.code[t]) != '0);
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

>>> sv/tcel_queue.sv
module tcel_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tcel_pkg::tcel_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output tcel_pkg::tcel_entry_t head_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcel_pkg::tcel_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> sv/tcel_back.sv
module tcel_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  tcel_pkg::tcel_entry_t          head_entry,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcel_pkg::EDGE_W-1:0]    edge_index,
  output logic                           end_of_cube,
  output logic                           no_surface
);

  logic                              fresh_r, fresh_nxt;
  logic [tcel_pkg::TET_NUM-1:0]      rem_r, rem_nxt;
  logic [tcel_pkg::CNT_W-1:0]        k_r, k_nxt;
  logic                              out_valid_r;
  logic [tcel_pkg::EDGE_W-1:0]       edge_r;
  logic                              last_r, empty_r;

  logic [tcel_pkg::TET_NUM-1:0]      cur_rem, rem_after;
  logic [tcel_pkg::TET_W-1:0]        t_sel;
  logic [tcel_pkg::CODE_W-1:0]       code;
  logic [tcel_pkg::CNT_W-1:0]        n_vert;
  tcel_pkg::local_row_t              lrow;
  tcel_pkg::edge_row_t               erow;
  logic [tcel_pkg::LOCAL_W-1:0]      local_e;
  logic [tcel_pkg::EDGE_W-1:0]       edge_sel;
  logic                              step, vdone, cube_empty, last;

  assign cur_rem = fresh_r ? head_entry.busy : rem_r;

  always_comb begin
    t_sel = '0;
    for (int t = tcel_pkg::TET_NUM - 1; t >= 0; t--) begin
      if (cur_rem[t]) begin
        t_sel = tcel_pkg::TET_W'(t);
      end
    end
  end

  assign code       = head_entry.code[t_sel];
  assign n_vert     = tcel_pkg::tet_count(code);
  assign lrow       = tcel_pkg::tet_local(code);
  assign erow       = tcel_pkg::tet_edge(t_sel);
  assign local_e    = lrow[k_r];
  assign edge_sel   = erow[local_e];
  assign cube_empty = (cur_rem == '0);
  assign vdone      = (k_r + 1'b1 == n_vert);

  always_comb begin
    rem_after = cur_rem;
    if (vdone) begin
      rem_after[t_sel] = 1'b0;
    end
  end

  assign last = cube_empty || (vdone && rem_after == '0);
  assign step = head_valid && (!out_valid_r || out_ready);
  assign pop  = step && last;

  always_comb begin
    fresh_nxt = fresh_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    if (step) begin
      if (last) begin
        fresh_nxt = 1'b1;
        k_nxt     = '0;
      end else begin
        fresh_nxt = 1'b0;
        rem_nxt   = rem_after;
        k_nxt     = vdone ? '0 : k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b1;
      rem_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fresh_r <= fresh_nxt;
      rem_r   <= rem_nxt;
      k_r     <= k_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      edge_r  <= cube_empty ? '0 : edge_sel;
      last_r  <= last;
      empty_r <= cube_empty;
    end
  end

  assign out_valid   = out_valid_r;
  assign edge_index  = edge_r;
  assign end_of_cube = last_r;
  assign no_surface  = empty_r;

endmodule
